@@ design/fpt_pkg.sv @@
// shared types, codes and constants of the fermat primality tester
`default_nettype none
package fpt_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned ROUND_W   = 6;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned STEP_W    = 5;
  localparam int unsigned TABLE_LEN = 25;

  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SEED   = 1'd1;

  localparam logic [ROUND_W-1:0] ROUNDS_RESET = 6'd30;
  localparam logic [DATA_W-1:0]  SEED_RESET   = 32'd1;
  localparam logic [DATA_W-1:0]  LFSR_MASK    = 32'hD000_0001;
  localparam logic [DATA_W-1:0]  TALLY_MAX    = 32'hFFFF_FFFF;

  // serial unit operations
  localparam logic [1:0] OP_DRAW = 2'd0;
  localparam logic [1:0] OP_GCD  = 2'd1;
  localparam logic [1:0] OP_SQR  = 2'd2;
  localparam logic [1:0] OP_MULA = 2'd3;

  localparam logic [6:0] SMALL_PRIMES [TABLE_LEN] = '{
    7'd2, 7'd3, 7'd5, 7'd7, 7'd11, 7'd13, 7'd17, 7'd19, 7'd23, 7'd29, 7'd31, 7'd37,
    7'd41, 7'd43, 7'd47, 7'd53, 7'd59, 7'd61, 7'd67, 7'd71, 7'd73, 7'd79, 7'd83,
    7'd89, 7'd97
  };

  typedef struct packed {
    logic       load;
    logic       round_clr;
    logic       round_inc;
    logic       start;
    logic [1:0] op;
    logic       gcd_init;
    logic       pow_init;
    logic       ebit_dec;
    logic       emit;
    logic       pass;
  } cmd_t;

  typedef struct packed {
    logic busy;
    logic below_two;
    logic small_hit;
    logic rounds_done;
    logic a_lt3;
    logic q_zero;
    logic p_one;
    logic e_bit;
    logic ebit_zero;
    logic r_one;
    logic out_free;
  } status_t;

  function automatic logic small_prime_hit(logic [DATA_W-1:0] x, int unsigned n);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < TABLE_LEN; i++) begin
      if ((i < n) && (x == DATA_W'(SMALL_PRIMES[i]))) hit = 1'b1;
    end
    return hit;
  endfunction

  function automatic logic [DATA_W-1:0] lfsr_next(logic [DATA_W-1:0] s);
    logic [DATA_W-1:0] n;
    n = s >> 1;
    if (s[0]) n = n ^ LFSR_MASK;
    return n;
  endfunction

endpackage
`default_nettype wire

@@ design/fpt_ifs.sv @@
// handshake channel interfaces of the fermat primality tester
`default_nettype none
interface fpt_in_if #(parameter int unsigned VALUE_WIDTH = 31);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] candidate;
  logic                   restart_count;
  modport source (output valid, candidate, restart_count, input ready);
  modport sink   (input valid, candidate, restart_count, output ready);
endinterface

interface fpt_out_if;
  logic        valid;
  logic        ready;
  logic        prime_flag;
  logic [31:0] prime_tally;
  modport source (output valid, prime_flag, prime_tally, input ready);
  modport sink   (input valid, prime_flag, prime_tally, output ready);
endinterface

interface fpt_cfg_if;
  logic        valid;
  logic        ready;
  logic [0:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

@@ design/fpt_datapath.sv @@
// datapath: config registers, lfsr, shared serial modular unit, tally and result register
`default_nettype none
module fpt_datapath #(
  parameter int unsigned VALUE_WIDTH       = 31,
  parameter int unsigned SMALL_PRIME_COUNT = 25
) (
  input  wire                           clk_i,
  input  wire                           rst_ni,
  input  fpt_pkg::cmd_t                 cmd_i,
  output fpt_pkg::status_t              sts_o,
  input  wire [VALUE_WIDTH-1:0]         cand_i,
  input  wire                           restart_i,
  input  wire                           cfg_we_i,
  input  wire [fpt_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire [fpt_pkg::DATA_W-1:0]     cfg_data_i,
  output logic                          out_valid_o,
  input  wire                           out_ready_i,
  output logic                          prime_flag_o,
  output logic [fpt_pkg::DATA_W-1:0]    prime_tally_o
);

  localparam int unsigned W   = VALUE_WIDTH;
  localparam int unsigned TW  = W + 2;
  localparam int unsigned EBW = $clog2(W);
  localparam int unsigned DW  = fpt_pkg::DATA_W;

  logic [fpt_pkg::ROUND_W-1:0] round_count_q, rnd_q;
  logic [DW-1:0]               lfsr_q, tally_q, out_tally_q, dv_q, lfsr_nx, seed_ld;
  logic [W-1:0]                x_q, e_q, a_q, p_q, q_q, r_q, acc_q, m_q, b_q;
  logic [W-1:0]                addend, acc_next;
  logic [EBW-1:0]              ebit_q;
  logic [fpt_pkg::STEP_W-1:0]  cnt_q;
  logic [1:0]                  op_q;
  logic                        mul_q, busy_q, out_valid_q, out_prime_q, last_step;
  logic [TW-1:0]               t, m1, m2, m3;
  logic [DW-1:0]               tally_nx;

  assign lfsr_nx   = fpt_pkg::lfsr_next(lfsr_q);
  assign seed_ld   = (cfg_data_i == '0) ? fpt_pkg::SEED_RESET : cfg_data_i;
  assign last_step = (cnt_q == '1);

  // one digit of shift-add modular multiply or restoring remainder
  assign addend = mul_q ? (dv_q[DW-1] ? b_q : '0) : W'(dv_q[DW-1]);
  assign t  = TW'({acc_q, 1'b0}) + TW'(addend);
  assign m1 = TW'(m_q);
  assign m2 = {m1[TW-2:0], 1'b0};
  assign m3 = m1 + m2;

  always_comb begin
    if (t >= m3) begin
      acc_next = W'(t - m3);
    end else if (t >= m2) begin
      acc_next = W'(t - m2);
    end else if (t >= m1) begin
      acc_next = W'(t - m1);
    end else begin
      acc_next = W'(t);
    end
  end

  assign tally_nx = (cmd_i.pass && (tally_q != fpt_pkg::TALLY_MAX)) ? tally_q + 1'b1 : tally_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      round_count_q <= fpt_pkg::ROUNDS_RESET;
      lfsr_q        <= fpt_pkg::SEED_RESET;
      tally_q       <= '0;
      rnd_q         <= '0;
      busy_q        <= 1'b0;
      cnt_q         <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == fpt_pkg::CFG_ROUNDS) begin
          round_count_q <= cfg_data_i[fpt_pkg::ROUND_W-1:0];
        end else if (cfg_idx_i == fpt_pkg::CFG_SEED) begin
          lfsr_q <= seed_ld;
        end
      end else if (cmd_i.start && (cmd_i.op == fpt_pkg::OP_DRAW)) begin
        lfsr_q <= lfsr_nx;
      end
      if (cmd_i.load && restart_i) begin
        tally_q <= '0;
      end else if (cmd_i.emit) begin
        tally_q <= tally_nx;
      end
      if (cmd_i.round_clr) begin
        rnd_q <= '0;
      end else if (cmd_i.round_inc) begin
        rnd_q <= rnd_q + 1'b1;
      end
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (last_step) busy_q <= 1'b0;
      end
      if (cmd_i.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= cand_i;
      e_q <= cand_i - 1'b1;
    end
    if (cmd_i.gcd_init) begin
      p_q <= x_q;
      q_q <= a_q;
    end
    if (cmd_i.pow_init) begin
      r_q    <= W'(1);
      ebit_q <= EBW'(W - 1);
    end else if (cmd_i.ebit_dec) begin
      ebit_q <= ebit_q - 1'b1;
    end
    if (cmd_i.start) begin
      op_q  <= cmd_i.op;
      acc_q <= '0;
      case (cmd_i.op)
        fpt_pkg::OP_DRAW: begin
          dv_q  <= {1'b0, lfsr_nx[DW-2:0]};
          m_q   <= x_q;
          b_q   <= '0;
          mul_q <= 1'b0;
        end
        fpt_pkg::OP_GCD: begin
          dv_q  <= DW'(p_q);
          m_q   <= q_q;
          b_q   <= '0;
          mul_q <= 1'b0;
        end
        fpt_pkg::OP_SQR: begin
          dv_q  <= DW'(r_q);
          m_q   <= x_q;
          b_q   <= r_q;
          mul_q <= 1'b1;
        end
        default: begin
          dv_q  <= DW'(r_q);
          m_q   <= x_q;
          b_q   <= a_q;
          mul_q <= 1'b1;
        end
      endcase
    end else if (busy_q) begin
      acc_q <= acc_next;
      dv_q  <= {dv_q[DW-2:0], 1'b0};
      if (last_step) begin
        case (op_q)
          fpt_pkg::OP_DRAW: a_q <= acc_next;
          fpt_pkg::OP_GCD: begin
            p_q <= q_q;
            q_q <= acc_next;
          end
          default: r_q <= acc_next;
        endcase
      end
    end
    if (cmd_i.emit) begin
      out_prime_q <= cmd_i.pass;
      out_tally_q <= tally_nx;
    end
  end

  assign sts_o.busy        = busy_q;
  assign sts_o.below_two   = (x_q < W'(2));
  assign sts_o.small_hit   = fpt_pkg::small_prime_hit(DW'(x_q), SMALL_PRIME_COUNT);
  assign sts_o.rounds_done = (rnd_q == round_count_q);
  assign sts_o.a_lt3       = (a_q < W'(3));
  assign sts_o.q_zero      = (q_q == '0);
  assign sts_o.p_one       = (p_q == W'(1));
  assign sts_o.e_bit       = e_q[ebit_q];
  assign sts_o.ebit_zero   = (ebit_q == '0);
  assign sts_o.r_one       = (r_q == W'(1));
  assign sts_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o   = out_valid_q;
  assign prime_flag_o  = out_prime_q;
  assign prime_tally_o = out_tally_q;

endmodule
`default_nettype wire

@@ design/fpt_ctrl.sv @@
// controller: sequences table check, base draws, gcd and modular exponentiation
`default_nettype none
module fpt_ctrl (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              in_valid_i,
  output logic             in_ready_o,
  input  fpt_pkg::status_t sts_i,
  output fpt_pkg::cmd_t    cmd_o
);

  localparam logic [3:0] S_IDLE      = 4'd0;
  localparam logic [3:0] S_CHECK     = 4'd1;
  localparam logic [3:0] S_ROUND     = 4'd2;
  localparam logic [3:0] S_DRAW_WAIT = 4'd3;
  localparam logic [3:0] S_DRAW_CHK  = 4'd4;
  localparam logic [3:0] S_GCD       = 4'd5;
  localparam logic [3:0] S_GCD_WAIT  = 4'd6;
  localparam logic [3:0] S_POW       = 4'd7;
  localparam logic [3:0] S_SQR_WAIT  = 4'd8;
  localparam logic [3:0] S_MUL_WAIT  = 4'd9;
  localparam logic [3:0] S_NEXT_BIT  = 4'd10;
  localparam logic [3:0] S_FINISH    = 4'd11;

  logic [3:0] state_q, state_d;
  logic       pass_q, pass_d;

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    pass_d  = pass_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts_i.below_two) begin
          pass_d  = 1'b0;
          state_d = S_FINISH;
        end else if (sts_i.small_hit) begin
          pass_d  = 1'b1;
          state_d = S_FINISH;
        end else begin
          cmd_o.round_clr = 1'b1;
          state_d         = S_ROUND;
        end
      end
      S_ROUND: begin
        if (sts_i.rounds_done) begin
          pass_d  = 1'b1;
          state_d = S_FINISH;
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = fpt_pkg::OP_DRAW;
          state_d     = S_DRAW_WAIT;
        end
      end
      S_DRAW_WAIT: begin
        if (!sts_i.busy) state_d = S_DRAW_CHK;
      end
      S_DRAW_CHK: begin
        if (sts_i.a_lt3) begin
          cmd_o.start = 1'b1;
          cmd_o.op    = fpt_pkg::OP_DRAW;
          state_d     = S_DRAW_WAIT;
        end else begin
          cmd_o.gcd_init = 1'b1;
          state_d        = S_GCD;
        end
      end
      S_GCD: begin
        if (sts_i.q_zero) begin
          if (sts_i.p_one) begin
            cmd_o.pow_init = 1'b1;
            state_d        = S_POW;
          end else begin
            pass_d  = 1'b0;
            state_d = S_FINISH;
          end
        end else begin
          cmd_o.start = 1'b1;
          cmd_o.op    = fpt_pkg::OP_GCD;
          state_d     = S_GCD_WAIT;
        end
      end
      S_GCD_WAIT: begin
        if (!sts_i.busy) state_d = S_GCD;
      end
      S_POW: begin
        cmd_o.start = 1'b1;
        cmd_o.op    = fpt_pkg::OP_SQR;
        state_d     = S_SQR_WAIT;
      end
      S_SQR_WAIT: begin
        if (!sts_i.busy) begin
          if (sts_i.e_bit) begin
            cmd_o.start = 1'b1;
            cmd_o.op    = fpt_pkg::OP_MULA;
            state_d     = S_MUL_WAIT;
          end else begin
            state_d = S_NEXT_BIT;
          end
        end
      end
      S_MUL_WAIT: begin
        if (!sts_i.busy) state_d = S_NEXT_BIT;
      end
      S_NEXT_BIT: begin
        if (!sts_i.ebit_zero) begin
          cmd_o.ebit_dec = 1'b1;
          state_d        = S_POW;
        end else if (sts_i.r_one) begin
          cmd_o.round_inc = 1'b1;
          state_d         = S_ROUND;
        end else begin
          pass_d  = 1'b0;
          state_d = S_FINISH;
        end
      end
      S_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.pass = pass_q;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
    end
  end

endmodule
`default_nettype wire

@@ design/fermat_primality_tester.sv @@
// Fermat primality tester: one candidate in, one verdict with running prime tally out.
// Candidates below 2 and the table primes go from the check state straight to the finish state,
// which hands the verdict to the output register; the controller then returns to idle for the
// next item. Every other candidate x runs up to round_count rounds on one shared bit-serial
// modular unit: each round draws a base (redrawn while below 3), runs Euclid remainder steps
// for the gcd of x and the base, and does square-and-multiply exponentiation over VALUE_WIDTH
// bits of x-1, with a multiply per set bit.
// A new item is taken only in idle; a finished result waits in the output register while the
// next candidate is taken.
`default_nettype none
module fermat_primality_tester #(
  parameter int unsigned VALUE_WIDTH       = 31,
  parameter int unsigned SMALL_PRIME_COUNT = 25
) (
  input  wire              clk_i,
  input  wire              rst_ni,
  fpt_in_if.sink           in_item,
  fpt_out_if.source        out_item,
  fpt_cfg_if.sink          cfg
);

  fpt_pkg::cmd_t    cmd;
  fpt_pkg::status_t sts;
  logic             in_ready;

  assign in_item.ready = in_ready;
  assign cfg.ready     = 1'b1;

  fpt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_item.valid),
    .in_ready_o (in_ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  fpt_datapath #(
    .VALUE_WIDTH       (VALUE_WIDTH),
    .SMALL_PRIME_COUNT (SMALL_PRIME_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .cand_i        (in_item.candidate),
    .restart_i     (in_item.restart_count),
    .cfg_we_i      (cfg.valid),
    .cfg_idx_i     (cfg.index),
    .cfg_data_i    (cfg.data),
    .out_valid_o   (out_item.valid),
    .out_ready_i   (out_item.ready),
    .prime_flag_o  (out_item.prime_flag),
    .prime_tally_o (out_item.prime_tally)
  );

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_item.valid && in_ready) |=> !in_ready)
    else $error("item taken while a candidate is in work");

  a_emit_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_item.valid || out_item.ready))
    else $error("result overwrote an item not yet taken");

  a_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |=> out_item.valid)
    else $error("result not presented after completion");

  a_no_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.start |-> !sts.busy)
    else $error("serial unit started while busy");
`endif

endmodule
`default_nettype wire
